>>> rtl/core/rsb_pkg.sv
package rsb_pkg;

    // framebuffer limits
    localparam int unsigned MAX_PITCH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;

    // field widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned CUR_W      = 22;
    localparam int unsigned COL_W      = 11;
    localparam int unsigned ADDR_W     = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLIT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_PITCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd4;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] PITCH_RST  = 11'd320;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd200;

    // item kinds
    localparam logic ITEM_START = 1'b0;
    localparam logic ITEM_DATA  = 1'b1;

    // stream byte codes
    localparam logic [7:0] CODE_SKIP_RUN = 8'd255;
    localparam logic [7:0] CODE_ROW_END  = 8'd254;
    localparam logic [7:0] CODE_SKIP_ONE = 8'd253;

    // clamp thresholds
    localparam logic [7:0] NIB_MAX  = 8'h0f;
    localparam logic [7:0] CLAMP_HI = 8'h1f;

    typedef enum logic [2:0] {
        BM_COPY     = 3'd0,
        BM_BLEND    = 3'd1,
        BM_HV_WRAP  = 3'd2,
        BM_HV_CLAMP = 3'd3,
        BM_HV_BLEND = 3'd4,
        BM_HALVE    = 3'd5,
        BM_BLACK    = 3'd6
    } blit_mode_t;

    function automatic logic [CFG_DATA_W-1:0] sat_pitch(input logic [CFG_DATA_W-1:0] v);
        return (v > CFG_DATA_W'(MAX_PITCH)) ? CFG_DATA_W'(MAX_PITCH) : v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] sat_height(input logic [CFG_DATA_W-1:0] v);
        return (v > CFG_DATA_W'(MAX_HEIGHT)) ? CFG_DATA_W'(MAX_HEIGHT) : v;
    endfunction

endpackage

>>> rtl/core/rle_sprite_blitter_top.sv
// datapath: each input item passes through the input register and then the result register
//   before its result is offered on the result channel
// throughput: one item per cycle, sustained while the result side takes transfers
// the cursor and column update in one pass each cycle, start items use one 11x11 multiply
// reset: synchronous active-low aresetn clears valid flags, sprite state and
//   configuration (pitch 320, height 200, end bound 64000, all else zero)
module rle_sprite_blitter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rsb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input item channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic signed [10:0]                s_origin_x,
    input  logic signed [10:0]                s_origin_y,
    input  logic [9:0]                        s_sprite_width,
    input  logic [7:0]                        s_data_byte,
    input  logic [7:0]                        s_dest_pixel,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_write_enable,
    output logic [rsb_pkg::ADDR_W-1:0]        m_write_address,
    output logic [7:0]                        m_write_data,
    output logic signed [rsb_pkg::CUR_W-1:0]  m_cursor_address,
    output logic                              m_stopped
);
    import rsb_pkg::*;

    // configuration registers
    logic [2:0]            blit_mode_reg;
    logic [3:0]            hue_reg;
    logic [7:0]            value_offset_reg;
    logic [CFG_DATA_W-1:0] pitch_reg;      // already saturated
    logic [CFG_DATA_W-1:0] height_reg;     // already saturated
    logic [CUR_W-1:0]      end_reg;        // pitch * height, kept alongside the config

    // input register
    logic                  in_valid_reg;
    logic                  in_mode_reg;
    logic signed [10:0]    in_ox_reg;
    logic signed [10:0]    in_oy_reg;
    logic [9:0]            in_width_reg;
    logic [7:0]            in_byte_reg;
    logic [7:0]            in_pixel_reg;

    // sprite state
    logic [CUR_W-1:0]      cursor_reg;
    logic [COL_W-1:0]      column_reg;
    logic [9:0]            row_width_reg;
    logic                  await_reg;
    logic                  halted_reg;

    // result register
    logic                  out_valid_reg;
    logic                  out_we_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [7:0]            out_data_reg;
    logic [CUR_W-1:0]      out_cursor_reg;
    logic                  out_stopped_reg;

    // next values
    logic [CUR_W-1:0]      cursor_next;
    logic [COL_W-1:0]      column_next;
    logic [9:0]            row_width_next;
    logic                  await_next;
    logic                  halted_next;
    logic                  we_next;
    logic [ADDR_W-1:0]     addr_next;
    logic [7:0]            data_next;

    logic                  process;
    logic signed [22:0]    start_prod;
    logic [CUR_W-1:0]      start_addr;
    logic [7:0]            shaded;
    logic [CFG_DATA_W-1:0] wr_pitch;
    logic [CFG_DATA_W-1:0] wr_height;
    logic [CUR_W-1:0]      end_next;

    // the stage fires when the input register holds an item and the result register is free or being drained
    assign process   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || process;
    assign cfg_ready = 1'b1;

    assign m_valid          = out_valid_reg;
    assign m_write_enable   = out_we_reg;
    assign m_write_address  = out_addr_reg;
    assign m_write_data     = out_data_reg;
    assign m_cursor_address = $signed(out_cursor_reg);
    assign m_stopped        = out_stopped_reg;

    // surface end bound follows each pitch or height write in the same edge
    always_comb begin
        wr_pitch  = pitch_reg;
        wr_height = height_reg;
        if (cfg_valid && cfg_index == REG_SURFACE_PITCH) begin
            wr_pitch = sat_pitch(cfg_data);
        end
        if (cfg_valid && cfg_index == REG_SURFACE_HEIGHT) begin
            wr_height = sat_height(cfg_data);
        end
        end_next = CUR_W'(wr_pitch * wr_height);
    end

    // start cursor: origin_y * pitch + origin_x, wrapped to the cursor width
    always_comb begin
        start_prod = in_oy_reg * $signed({1'b0, pitch_reg});
        start_addr = start_prod[CUR_W-1:0] + CUR_W'(in_ox_reg);
    end

    // pixel shading per blit mode
    always_comb begin
        logic [7:0] hv_sum;
        logic [3:0] hv_clamp;
        logic [4:0] blend_sum;
        logic [4:0] hv_blend_sum;
        hv_sum = {4'd0, in_byte_reg[3:0]} + value_offset_reg;
        if (hv_sum <= NIB_MAX) begin
            hv_clamp = hv_sum[3:0];
        end else if (hv_sum >= CLAMP_HI) begin
            hv_clamp = 4'd0;
        end else begin
            hv_clamp = 4'hf;
        end
        blend_sum    = {1'b0, in_pixel_reg[3:0]} + {1'b0, in_byte_reg[3:0]};
        hv_blend_sum = {1'b0, in_pixel_reg[3:0]} + {1'b0, hv_clamp};
        case (blit_mode_reg)
            BM_BLEND:    shaded = {in_byte_reg[7:4], blend_sum[4:1]};
            BM_HV_WRAP:  shaded = {hue_reg, 4'd0} | hv_sum;
            BM_HV_CLAMP: shaded = {hue_reg, hv_clamp};
            BM_HV_BLEND: shaded = {hue_reg, hv_blend_sum[4:1]};
            BM_HALVE:    shaded = {in_pixel_reg[7:4], 1'b0, in_pixel_reg[3:1]};
            BM_BLACK:    shaded = 8'd0;
            default:     shaded = in_byte_reg;   // copy, unused code copies too
        endcase
    end

    // cursor / column update for one item
    always_comb begin
        logic [COL_W-1:0] adv;
        logic             do_adv;
        logic             check;
        logic [CUR_W-1:0] cur_a;
        logic [COL_W-1:0] col_a;
        adv            = '0;
        do_adv         = 1'b0;
        check          = 1'b0;
        cursor_next    = cursor_reg;
        column_next    = column_reg;
        row_width_next = row_width_reg;
        await_next     = await_reg;
        halted_next    = halted_reg;
        we_next        = 1'b0;
        addr_next      = '0;
        data_next      = '0;
        cur_a          = cursor_reg;
        col_a          = column_reg;

        if (in_mode_reg == ITEM_START) begin
            cursor_next    = start_addr;
            column_next    = '0;
            row_width_next = in_width_reg;
            await_next     = 1'b0;
            halted_next    = 1'b0;
        end else if (!halted_reg) begin
            check = 1'b1;
            if (await_reg) begin
                // byte after a skip-run code is the run length
                await_next = 1'b0;
                adv        = COL_W'(in_byte_reg);
                do_adv     = 1'b1;
            end else if (in_byte_reg == CODE_SKIP_RUN) begin
                await_next = 1'b1;
                check      = 1'b0;
            end else if (in_byte_reg == CODE_ROW_END) begin
                if ({1'b0, row_width_reg} > column_reg) begin
                    adv    = {1'b0, row_width_reg} - column_reg;
                    do_adv = 1'b1;
                end
            end else if (in_byte_reg == CODE_SKIP_ONE) begin
                adv    = COL_W'(1);
                do_adv = 1'b1;
            end else if ($signed(cursor_reg) >= $signed(end_reg)) begin
                // opaque pixel past the surface end stops the sprite
                halted_next = 1'b1;
                check       = 1'b0;
            end else begin
                if (!cursor_reg[CUR_W-1]) begin
                    we_next   = 1'b1;
                    addr_next = cursor_reg[ADDR_W-1:0];
                    data_next = shaded;
                end
                adv    = COL_W'(1);
                do_adv = 1'b1;
            end

            if (do_adv) begin
                cur_a = cursor_reg + CUR_W'(adv);
                col_a = column_reg + adv;
            end

            // row wrap
            if (check && col_a >= {1'b0, row_width_reg}) begin
                cursor_next = cur_a + CUR_W'(pitch_reg) - CUR_W'(col_a);
                column_next = '0;
            end else begin
                cursor_next = cur_a;
                column_next = col_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blit_mode_reg    <= '0;
            hue_reg          <= '0;
            value_offset_reg <= '0;
            pitch_reg        <= PITCH_RST;
            height_reg       <= HEIGHT_RST;
            end_reg          <= CUR_W'(PITCH_RST * HEIGHT_RST);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BLIT_MODE:      blit_mode_reg    <= cfg_data[2:0];
                REG_HUE:            hue_reg          <= cfg_data[3:0];
                REG_VALUE_OFFSET:   value_offset_reg <= cfg_data[7:0];
                REG_SURFACE_PITCH:  pitch_reg        <= wr_pitch;
                REG_SURFACE_HEIGHT: height_reg       <= wr_height;
                default: ;
            endcase
            end_reg <= end_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (process) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg  <= s_mode;
            in_ox_reg    <= s_origin_x;
            in_oy_reg    <= s_origin_y;
            in_width_reg <= s_sprite_width;
            in_byte_reg  <= s_data_byte;
            in_pixel_reg <= s_dest_pixel;
        end
    end

    // sprite state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg    <= '0;
            column_reg    <= '0;
            row_width_reg <= '0;
            await_reg     <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (process) begin
            cursor_reg    <= cursor_next;
            column_reg    <= column_next;
            row_width_reg <= row_width_next;
            await_reg     <= await_next;
            halted_reg    <= halted_next;
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (process) begin
            out_we_reg      <= we_next;
            out_addr_reg    <= addr_next;
            out_data_reg    <= data_next;
            out_cursor_reg  <= cursor_next;
            out_stopped_reg <= halted_next;
        end
    end

endmodule
